>>> rtl/stis_pkg.sv
// shared types, constants and helpers for the sorted key table
package stis_pkg;

   localparam int TABLE_CAPACITY_DEF = 1024;
   localparam int KEY_W    = 32;
   localparam int METHOD_W = 2;
   localparam int POS_W    = 10;
   localparam int CNT_W    = 11;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [METHOD_W-1:0] METHOD_BINARY    = 2'd0;
   localparam logic [METHOD_W-1:0] METHOD_LINEAR    = 2'd1;
   localparam logic [METHOD_W-1:0] METHOD_TRANSPOSE = 2'd2;
   localparam logic [METHOD_W-1:0] METHOD_INVALID   = 2'd3;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

   function automatic logic key_less(input logic signed [KEY_W-1:0] a,
                                     input logic signed [KEY_W-1:0] b);
      return a < b;
   endfunction

endpackage

>>> rtl/stis_key_ram.sv
// single-port-write, single-port-read key memory with registered read data
module stis_key_ram #(
   parameter int DEPTH = stis_pkg::TABLE_CAPACITY_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                                clock,
   input  stis_pkg::ram_ctl_type               ctl,
   input  logic [AW-1:0]                       wr_addr,
   input  logic signed [stis_pkg::KEY_W-1:0]   wr_data,
   input  logic [AW-1:0]                       rd_addr,
   output logic signed [stis_pkg::KEY_W-1:0]   rd_data
);
   import stis_pkg::*;

   logic signed [KEY_W-1:0] mem [DEPTH];
   logic signed [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sorted_table_insert_search.sv
// sorted key table top level: insert and binary or linear search over a key memory
// inserts into an empty or unordered table and error cases give the result straight from idle
// ordered insert shifts each larger key up one place in ST_INS_CMP, then stores the new key
// binary search runs ST_BS_ADDR then ST_BS_CMP per probe; linear search compares keys in order
// in ST_LS_CMP, plus ST_LS_SWAP for a transpose; one transaction at a time, busy high until the result strobe, no stall
// reset clears the fill count and sets ordered mode; the key memory is not cleared
module sorted_table_insert_search #(
   parameter int TABLE_CAPACITY = stis_pkg::TABLE_CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_op,
   input  logic signed [stis_pkg::KEY_W-1:0]     req_key,
   input  logic [stis_pkg::METHOD_W-1:0]         req_method,
   input  logic                                  csr_we,
   input  logic                                  csr_wdata,
   output logic                                  rsp_strobe,
   output logic                                  rsp_status,
   output logic                                  rsp_found,
   output logic [stis_pkg::POS_W-1:0]            rsp_position,
   output logic [stis_pkg::CNT_W-1:0]            rsp_op_count
);
   import stis_pkg::*;

   localparam int AW = $clog2(TABLE_CAPACITY);
   localparam int FW = $clog2(TABLE_CAPACITY + 1);
   localparam int CW = $clog2(TABLE_CAPACITY + 2);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_INS_CMP   = 7'b0000010,
      ST_INS_STORE = 7'b0000100,
      ST_BS_ADDR   = 7'b0001000,
      ST_BS_CMP    = 7'b0010000,
      ST_LS_CMP    = 7'b0100000,
      ST_LS_SWAP   = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic                    mode_ff;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [METHOD_W-1:0]     method_ff, method_in;
   logic                    op_ff, op_in;
   logic [FW-1:0]           idx_ff, idx_in;
   logic [FW-1:0]           lo_ff, lo_in;
   logic [FW-1:0]           hi_ff, hi_in;
   logic [FW-1:0]           mid_ff, mid_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic signed [KEY_W-1:0] prev_ff, prev_in;

   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]        rsp_position_ff, rsp_position_in;
   logic [CNT_W-1:0]        rsp_op_count_ff, rsp_op_count_in;

   ram_ctl_type             ram_ctl;
   logic [AW-1:0]           wr_addr;
   logic signed [KEY_W-1:0] wr_data;
   logic [AW-1:0]           rd_addr;
   logic signed [KEY_W-1:0] rd_data;

   logic                    emit;
   logic                    em_status;
   logic                    em_found;
   logic [FW-1:0]           em_pos;
   logic [CW-1:0]           em_cnt;

   logic [FW-1:0]           fill_m1, fill_p1;
   logic [FW-1:0]           idx_m1, idx_m2, idx_p1;
   logic [FW-1:0]           mid_calc, mid_p1;
   logic [FW-1:0]           lo_new, hi_new;
   logic                    key_hit, key_lt_rd, rd_lt_key;

   stis_key_ram #(
      .DEPTH (TABLE_CAPACITY)
   ) u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign fill_m1   = fill_ff - FW'(1);
   assign fill_p1   = fill_ff + FW'(1);
   assign idx_m1    = idx_ff - FW'(1);
   assign idx_m2    = idx_ff - FW'(2);
   assign idx_p1    = idx_ff + FW'(1);
   assign mid_calc  = lo_ff + ((hi_ff - lo_ff - FW'(1)) >> 1);
   assign mid_p1    = mid_ff + FW'(1);
   assign key_hit   = (rd_data == key_ff);
   assign key_lt_rd = key_less(key_ff, rd_data);
   assign rd_lt_key = key_less(rd_data, key_ff);

   always_comb begin
      lo_new = lo_ff;
      hi_new = hi_ff;
      if (rd_lt_key) begin
         lo_new = mid_p1;
      end else begin
         hi_new = mid_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      key_in        = key_ff;
      method_in     = method_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      cnt_in        = cnt_ff;
      prev_in       = prev_ff;
      ram_ctl.wr_en = 1'b0;
      ram_ctl.rd_en = 1'b0;
      wr_addr       = '0;
      wr_data       = key_ff;
      rd_addr       = '0;
      emit          = 1'b0;
      em_status     = STATUS_OK;
      em_found      = 1'b0;
      em_pos        = '0;
      em_cnt        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in    = req_key;
               method_in = req_method;
               op_in     = req_op;
               if (req_op == OP_INSERT) begin
                  if (fill_ff >= FW'(TABLE_CAPACITY)) begin
                     emit      = 1'b1;
                     em_status = STATUS_ERROR;
                  end else if (!mode_ff || fill_ff == '0) begin
                     ram_ctl.wr_en = 1'b1;
                     wr_addr       = fill_ff[AW-1:0];
                     wr_data       = req_key;
                     fill_in       = fill_p1;
                     emit          = 1'b1;
                     em_pos        = fill_ff;
                     em_cnt        = mode_ff ? CW'(2) : CW'(1);
                  end else begin
                     ram_ctl.rd_en = 1'b1;
                     rd_addr       = fill_m1[AW-1:0];
                     idx_in        = fill_ff;
                     cnt_in        = CW'(2);
                     state_in      = ST_INS_CMP;
                  end
               end else begin
                  if (fill_ff == '0 || req_method == METHOD_INVALID ||
                      (req_method == METHOD_BINARY && !mode_ff)) begin
                     emit      = 1'b1;
                     em_status = STATUS_ERROR;
                  end else if (req_method == METHOD_BINARY) begin
                     lo_in    = '0;
                     hi_in    = fill_ff;
                     cnt_in   = '0;
                     state_in = ST_BS_ADDR;
                  end else begin
                     ram_ctl.rd_en = 1'b1;
                     rd_addr       = '0;
                     idx_in        = '0;
                     cnt_in        = '0;
                     state_in      = ST_LS_CMP;
                  end
               end
            end
         end
         ST_INS_CMP: begin
            ram_ctl.wr_en = 1'b1;
            wr_addr       = idx_ff[AW-1:0];
            if (key_lt_rd) begin
               wr_data       = rd_data;
               cnt_in        = cnt_ff + CW'(1);
               idx_in        = idx_m1;
               ram_ctl.rd_en = 1'b1;
               rd_addr       = idx_m2[AW-1:0];
               if (idx_ff == FW'(1)) begin
                  state_in = ST_INS_STORE;
               end
            end else begin
               wr_data  = key_ff;
               fill_in  = fill_p1;
               emit     = 1'b1;
               em_pos   = idx_ff;
               em_cnt   = cnt_ff;
               state_in = ST_IDLE;
            end
         end
         ST_INS_STORE: begin
            ram_ctl.wr_en = 1'b1;
            wr_addr       = '0;
            wr_data       = key_ff;
            fill_in       = fill_p1;
            emit          = 1'b1;
            em_pos        = '0;
            em_cnt        = cnt_ff;
            state_in      = ST_IDLE;
         end
         ST_BS_ADDR: begin
            ram_ctl.rd_en = 1'b1;
            rd_addr       = mid_calc[AW-1:0];
            mid_in        = mid_calc;
            state_in      = ST_BS_CMP;
         end
         ST_BS_CMP: begin
            cnt_in = cnt_ff + CW'(1);
            if (key_hit) begin
               emit     = 1'b1;
               em_found = 1'b1;
               em_pos   = mid_ff;
               em_cnt   = cnt_ff + CW'(1);
               state_in = ST_IDLE;
            end else begin
               lo_in = lo_new;
               hi_in = hi_new;
               if (lo_new < hi_new) begin
                  state_in = ST_BS_ADDR;
               end else begin
                  emit     = 1'b1;
                  em_cnt   = cnt_ff + CW'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LS_CMP: begin
            prev_in = rd_data;
            if (key_hit) begin
               if (method_ff == METHOD_TRANSPOSE && idx_ff != '0) begin
                  ram_ctl.wr_en = 1'b1;
                  wr_addr       = idx_ff[AW-1:0];
                  wr_data       = prev_ff;
                  cnt_in        = CW'(idx_p1);
                  state_in      = ST_LS_SWAP;
               end else begin
                  emit     = 1'b1;
                  em_found = 1'b1;
                  em_pos   = idx_ff;
                  em_cnt   = CW'(idx_p1);
                  state_in = ST_IDLE;
               end
            end else if (idx_p1 < fill_ff) begin
               ram_ctl.rd_en = 1'b1;
               rd_addr       = idx_p1[AW-1:0];
               idx_in        = idx_p1;
            end else begin
               emit     = 1'b1;
               em_cnt   = CW'(idx_p1);
               state_in = ST_IDLE;
            end
         end
         ST_LS_SWAP: begin
            ram_ctl.wr_en = 1'b1;
            wr_addr       = idx_m1[AW-1:0];
            wr_data       = key_ff;
            emit          = 1'b1;
            em_found      = 1'b1;
            em_pos        = idx_m1;
            em_cnt        = cnt_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_strobe_in   = emit;
      rsp_status_in   = em_status;
      rsp_found_in    = em_found;
      rsp_position_in = POS_W'(em_pos);
      rsp_op_count_in = CNT_W'(em_cnt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         mode_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      method_ff       <= method_in;
      op_ff           <= op_in;
      idx_ff          <= idx_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      cnt_ff          <= cnt_in;
      prev_ff         <= prev_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_op_count_ff <= rsp_op_count_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_op_count = rsp_op_count_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(TABLE_CAPACITY))
      else $error("fill count above capacity");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == ST_IDLE)
      else $error("result strobe while transaction still running");

   a_insert_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && op_ff == OP_INSERT && rsp_status_ff == STATUS_OK && !$past(reset)
      |-> fill_ff == $past(fill_ff) + FW'(1))
      else $error("good insert did not add one key");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_status_ff == STATUS_ERROR
      |-> !rsp_found_ff && rsp_position_ff == '0 && rsp_op_count_ff == '0)
      else $error("error result carries nonzero fields");

   a_search_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BS_CMP || state_ff == ST_LS_CMP |=> $stable(fill_ff))
      else $error("search changed the fill count");

endmodule
